// ----- rtl/smde_pkg.sv -----
package smde_pkg;

  // sizes of the stores
  localparam int MAX_ITEMS   = 256;
  localparam int LEVEL_COUNT = 16;

  localparam int IDX_W    = $clog2(MAX_ITEMS);
  localparam int POS_W    = $clog2(MAX_ITEMS + 1);
  localparam int LVL_W    = $clog2(LEVEL_COUNT);
  localparam int CNT_W    = 9;
  localparam int CODE_W   = 4;
  localparam int ITEM_W   = 8;
  localparam int FIELD_W  = 8;
  localparam int CMD_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int TALLY_W  = 20;
  localparam int WEIGHT_W = 32;
  localparam int DELTA_W  = 61;
  localparam int PROD_W   = TALLY_W + WEIGHT_W;
  localparam int ACC_W    = 64;
  localparam int WSEL_W   = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_CODE   = 3'd0,
    CMD_WR_ORDER  = 3'd1,
    CMD_WR_WEIGHT = 3'd2,
    CMD_EVAL_SWAP = 3'd3,
    CMD_EVAL_MOVE = 3'd4
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_P1,
    ST_RD_P2,
    ST_CAP_P2,
    ST_OUTER_RD,
    ST_OUTER_CAP,
    ST_WALK_SETUP,
    ST_WALK,
    ST_DRAIN,
    ST_SUM,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    AMT_CONST,
    AMT_SWAP,
    AMT_STEP
  } amt_mode_t;

  // control from the sequencer to the tally and weight unit
  typedef struct packed {
    logic                       clr;
    logic                       add_en;
    logic [CODE_W-1:0]          add_code;
    logic signed [TALLY_W-1:0]  add_amt;
    logic                       wt_we;
    logic [LVL_W-1:0]           wt_idx;
    logic signed [WEIGHT_W-1:0] wt_val;
    logic                       sum_start;
  } tally_ctl_t;

  typedef struct packed {
    logic                      done;
    logic signed [DELTA_W-1:0] delta;
  } tally_res_t;

  // clamp the accumulated sum into the result range
  function automatic logic signed [DELTA_W-1:0] sat_delta(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] dmax;
    logic signed [ACC_W-1:0] dmin;
    dmax = {{(ACC_W-DELTA_W+1){1'b0}}, {(DELTA_W-1){1'b1}}};
    dmin = ~dmax;
    if (a > dmax) return dmax[DELTA_W-1:0];
    else if (a < dmin) return dmin[DELTA_W-1:0];
    else return a[DELTA_W-1:0];
  endfunction

endpackage

// ----- rtl/smde_if.sv -----
interface smde_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [smde_pkg::CMD_W-1:0]           cmd;
  logic [smde_pkg::FIELD_W-1:0]         first_index;
  logic [smde_pkg::FIELD_W-1:0]         second_index;
  logic signed [smde_pkg::VALUE_W-1:0]  write_value;

  modport source (output valid, cmd, first_index, second_index, write_value, input ready);
  modport sink (input valid, cmd, first_index, second_index, write_value, output ready);
endinterface

interface smde_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [smde_pkg::DELTA_W-1:0]  delta;
  logic                                 status;

  modport source (output valid, delta, status, input ready);
  modport sink (input valid, delta, status, output ready);
endinterface

interface smde_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [smde_pkg::CNT_W-1:0]   item_count;

  modport source (output valid, item_count, input ready);
  modport sink (input valid, item_count, output ready);
endinterface

// ----- rtl/smde_tally.sv -----
module smde_tally (
  input  logic                 clk,
  input  logic                 rst,
  input  smde_pkg::tally_ctl_t ctl,
  output smde_pkg::tally_res_t res
);
  import smde_pkg::*;

  logic signed [TALLY_W-1:0]  tally [LEVEL_COUNT];
  logic signed [WEIGHT_W-1:0] weight [LEVEL_COUNT];

  logic                       run;
  logic [LVL_W:0]             k;
  logic                       pvalid;
  logic                       plast;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;
  logic                       fin;

  // per-level tallies, cleared at the start of each valid evaluation
  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      for (int i = 0; i < LEVEL_COUNT; i++) tally[i] <= '0;
    end else if (ctl.add_en) begin
      tally[ctl.add_code[LVL_W-1:0]] <= tally[ctl.add_code[LVL_W-1:0]] + ctl.add_amt;
    end
  end

  // level weights
  always_ff @(posedge clk) begin
    if (ctl.wt_we) weight[ctl.wt_idx] <= ctl.wt_val;
  end

  // one level per cycle: multiply, then accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      run    <= 1'b0;
      k      <= '0;
      pvalid <= 1'b0;
      plast  <= 1'b0;
      fin    <= 1'b0;
    end else begin
      fin <= pvalid && plast;
      if (ctl.sum_start) begin
        run    <= 1'b1;
        k      <= '0;
        pvalid <= 1'b0;
        plast  <= 1'b0;
      end else begin
        pvalid <= run;
        plast  <= run && (k == (LVL_W+1)'(LEVEL_COUNT - 1));
        if (run) begin
          k <= k + 1'b1;
          if (k == (LVL_W+1)'(LEVEL_COUNT - 1)) run <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= tally[k[LVL_W-1:0]] * weight[k[LVL_W-1:0]];
    if (ctl.sum_start) acc <= '0;
    else if (pvalid) acc <= acc + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
  end

  assign res.done  = fin;
  assign res.delta = sat_delta(acc);

endmodule

// ----- rtl/seriation_move_delta_engine_core.sv -----
// Seriation move-delta engine. Holds an item-by-item matrix of 4-bit level codes and the
// item ordering in synchronous-read memories, with 16 signed Q16.16 level weights.
// Write commands (code, ordering entry, level weight) take effect when accepted. An evaluate
// command walks the ordering through a three-stage read pipeline (ordering read, code read,
// tally update), one matrix entry per cycle while a walk runs. A weighted sum of the 16 levels
// ends every valid evaluation. Results leave through an output register, so write commands
// are taken while a result waits; one evaluation runs at a time.
// Equal or out-of-range positions answer status 1, delta 0 without a walk.
module seriation_move_delta_engine_core (
  input  logic       clk,
  input  logic       rst,
  smde_in_if.sink    in_ch,
  smde_out_if.source out_ch,
  smde_cfg_if.sink   cfg_ch
);
  import smde_pkg::*;

  // memories
  logic [CODE_W-1:0] code_mem [MAX_ITEMS*MAX_ITEMS];
  logic [ITEM_W-1:0] order_mem [MAX_ITEMS];
  logic [ITEM_W-1:0] order_q;
  logic [CODE_W-1:0] code_q;
  logic [IDX_W-1:0]  order_raddr;
  logic [2*IDX_W-1:0] code_raddr;

  state_t state, state_next;

  logic [CNT_W-1:0] item_count;
  logic [POS_W-1:0] n_eff;

  logic in_acc;
  logic is_eval;
  logic bad_pos;
  cmd_t cmd;

  // evaluation registers
  logic [IDX_W-1:0]  s1, s2, p1, p2, fcol, span;
  logic              is_move, up;
  logic [POS_W-1:0]  apos, ohi;
  logic [WSEL_W-1:0] wsel;

  // walk registers
  logic [POS_W-1:0]          pos, hi_r;
  logic [IDX_W-1:0]          fitem_r;
  logic                      frow_r, neg_r;
  amt_mode_t                 mode_r;
  logic [IDX_W-1:0]          base_r;
  logic signed [TALLY_W-1:0] step_r;

  // walk parameters for the next walk
  logic [IDX_W-1:0]  lo_a, hi_a;
  logic [POS_W-1:0]  hi_a1, olo;
  logic [POS_W-1:0]  w_lo, w_hi;
  logic [IDX_W-1:0]  w_fitem, w_base;
  logic              w_frow, w_neg;
  amt_mode_t         w_mode;

  logic walk_issue, walk_end, last_walk, outer_more, pipe_empty;
  logic [POS_W-1:0]          d1, d2;
  logic signed [TALLY_W-1:0] raw_amt, issue_amt;

  // pipeline stages
  logic                      st1_valid, st1_frow, st2_valid;
  logic [IDX_W-1:0]          st1_fitem;
  logic signed [TALLY_W-1:0] st1_amt, st2_amt;

  tally_ctl_t tc;
  tally_res_t tr;

  // result register
  logic                      out_valid;
  logic signed [DELTA_W-1:0] out_delta, res_delta;
  logic                      out_status, res_status;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state == ST_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cmd          = cmd_t'(in_ch.cmd);
  assign is_eval      = (cmd == CMD_EVAL_SWAP) || (cmd == CMD_EVAL_MOVE);
  assign n_eff = (item_count > CNT_W'(MAX_ITEMS)) ? POS_W'(MAX_ITEMS) : POS_W'(item_count);
  assign bad_pos = (in_ch.first_index == in_ch.second_index)
                || (POS_W'(in_ch.first_index) >= n_eff)
                || (POS_W'(in_ch.second_index) >= n_eff);

  // item count register
  always_ff @(posedge clk) begin
    if (rst) item_count <= CNT_W'(MAX_ITEMS);
    else if (cfg_ch.valid && cfg_ch.ready) item_count <= cfg_ch.item_count;
  end

  // memory writes and registered reads
  always_ff @(posedge clk) begin
    if (in_acc && (cmd == CMD_WR_CODE))
      code_mem[{in_ch.first_index[IDX_W-1:0], in_ch.second_index[IDX_W-1:0]}]
        <= in_ch.write_value[CODE_W-1:0];
    code_q <= code_mem[code_raddr];
  end

  always_ff @(posedge clk) begin
    if (in_acc && (cmd == CMD_WR_ORDER))
      order_mem[in_ch.first_index[IDX_W-1:0]] <= in_ch.write_value[ITEM_W-1:0];
    order_q <= order_mem[order_raddr];
  end

  // ordering read address
  always_comb begin
    case (state)
      ST_RD_P1:    order_raddr = s1;
      ST_RD_P2:    order_raddr = s2;
      ST_OUTER_RD: order_raddr = apos[IDX_W-1:0];
      default:     order_raddr = pos[IDX_W-1:0];
    endcase
  end

  assign code_raddr = st1_frow ? {st1_fitem, order_q[IDX_W-1:0]}
                               : {order_q[IDX_W-1:0], st1_fitem};

  // walk parameters by walk number
  assign lo_a  = up ? s1 : s2;
  assign hi_a  = up ? s2 : s1;
  assign hi_a1 = POS_W'(hi_a) + 1'b1;
  assign olo   = up ? POS_W'(lo_a) + 1'b1 : POS_W'(lo_a);

  always_comb begin
    w_lo    = '0;
    w_hi    = n_eff;
    w_fitem = p1;
    w_frow  = 1'b1;
    w_neg   = 1'b0;
    w_mode  = AMT_CONST;
    w_base  = span;
    if (!is_move) begin
      w_mode  = AMT_SWAP;
      w_fitem = (wsel == '0) ? p2 : p1;
      w_neg   = (wsel != '0);
    end else begin
      case (wsel)
        WSEL_W'(0): begin
          w_lo = hi_a1; w_frow = 1'b0; w_fitem = fcol; w_base = IDX_W'(1); w_neg = !up;
        end
        WSEL_W'(1): begin
          w_hi = POS_W'(lo_a); w_frow = 1'b0; w_fitem = fcol; w_base = IDX_W'(1); w_neg = up;
        end
        WSEL_W'(2): begin
          w_hi = POS_W'(lo_a); w_neg = !up;
        end
        WSEL_W'(3): begin
          w_lo = hi_a1; w_neg = up;
        end
        default: begin
          w_lo = olo; w_hi = olo + POS_W'(span); w_mode = AMT_STEP; w_neg = !up;
        end
      endcase
    end
  end

  // per-pair amount
  assign d1 = (pos > POS_W'(s1)) ? pos - POS_W'(s1) : POS_W'(s1) - pos;
  assign d2 = (pos > POS_W'(s2)) ? pos - POS_W'(s2) : POS_W'(s2) - pos;

  always_comb begin
    case (mode_r)
      AMT_SWAP: raw_amt = TALLY_W'(d1) - TALLY_W'(d2);
      AMT_STEP: raw_amt = step_r - TALLY_W'(2);
      default:  raw_amt = TALLY_W'(base_r);
    endcase
  end
  assign issue_amt = neg_r ? -raw_amt : raw_amt;

  assign walk_issue = (state == ST_WALK) && (pos < hi_r);
  assign walk_end   = (state == ST_WALK) && (pos >= hi_r);
  assign last_walk  = is_move ? (wsel == WSEL_W'(4)) : (wsel != '0);
  assign outer_more = (apos + 1'b1) < ohi;
  assign pipe_empty = !st1_valid && !st2_valid;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc && is_eval) state_next = bad_pos ? ST_DONE : ST_RD_P1;
      end
      ST_RD_P1:     state_next = ST_RD_P2;
      ST_RD_P2:     state_next = ST_CAP_P2;
      ST_CAP_P2:    state_next = is_move ? ST_OUTER_RD : ST_WALK_SETUP;
      ST_OUTER_RD:  state_next = ST_OUTER_CAP;
      ST_OUTER_CAP: state_next = ST_WALK_SETUP;
      ST_WALK_SETUP: state_next = ST_WALK;
      ST_WALK: begin
        if (walk_end) begin
          if (last_walk) state_next = ST_DRAIN;
          else if (is_move && (wsel == WSEL_W'(1)) && outer_more) state_next = ST_OUTER_RD;
          else state_next = ST_WALK_SETUP;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty) state_next = ST_SUM;
      end
      ST_SUM: begin
        if (tr.done) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ch.ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // evaluation and walk registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_acc && is_eval) begin
          s1         <= in_ch.first_index[IDX_W-1:0];
          s2         <= in_ch.second_index[IDX_W-1:0];
          is_move    <= (cmd == CMD_EVAL_MOVE);
          up         <= in_ch.second_index > in_ch.first_index;
          span       <= (in_ch.second_index > in_ch.first_index)
                        ? IDX_W'(in_ch.second_index - in_ch.first_index)
                        : IDX_W'(in_ch.first_index - in_ch.second_index);
          wsel       <= '0;
          res_delta  <= '0;
          res_status <= bad_pos;
        end
      end
      ST_RD_P2:  p1 <= order_q[IDX_W-1:0];
      ST_CAP_P2: begin
        p2   <= order_q[IDX_W-1:0];
        apos <= olo;
        ohi  <= olo + POS_W'(span);
      end
      ST_OUTER_CAP: begin
        fcol <= order_q[IDX_W-1:0];
        wsel <= '0;
      end
      ST_WALK_SETUP: begin
        pos     <= w_lo;
        hi_r    <= w_hi;
        fitem_r <= w_fitem;
        frow_r  <= w_frow;
        neg_r   <= w_neg;
        mode_r  <= w_mode;
        base_r  <= w_base;
        step_r  <= TALLY_W'(span) + TALLY_W'(1);
      end
      ST_WALK: begin
        if (walk_issue) begin
          pos <= pos + 1'b1;
          if (mode_r == AMT_STEP) step_r <= step_r - TALLY_W'(2);
        end else begin
          if (is_move && (wsel == WSEL_W'(1)) && outer_more) apos <= apos + 1'b1;
          else wsel <= wsel + 1'b1;
        end
      end
      ST_SUM: begin
        if (tr.done) begin
          res_delta  <= tr.delta;
          res_status <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  // read pipeline: ordering read, code read, tally update
  always_ff @(posedge clk) begin
    if (rst) begin
      st1_valid <= 1'b0;
      st2_valid <= 1'b0;
    end else begin
      st1_valid <= walk_issue
                   && !((mode_r == AMT_SWAP) && ((pos == POS_W'(s1)) || (pos == POS_W'(s2))));
      st2_valid <= st1_valid;
    end
  end

  always_ff @(posedge clk) begin
    st1_fitem <= fitem_r;
    st1_frow  <= frow_r;
    st1_amt   <= issue_amt;
    st2_amt   <= st1_amt;
  end

  // tally unit control
  always_comb begin
    tc.clr       = in_acc && is_eval && !bad_pos;
    tc.add_en    = st2_valid && (32'(code_q) < LEVEL_COUNT);
    tc.add_code  = code_q;
    tc.add_amt   = st2_amt;
    tc.wt_we     = in_acc && (cmd == CMD_WR_WEIGHT) && (32'(in_ch.first_index) < LEVEL_COUNT);
    tc.wt_idx    = in_ch.first_index[LVL_W-1:0];
    tc.wt_val    = in_ch.write_value;
    tc.sum_start = (state == ST_DRAIN) && pipe_empty;
  end

  smde_tally u_tally (
    .clk (clk),
    .rst (rst),
    .ctl (tc),
    .res (tr)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DONE) && (!out_valid || out_ch.ready)) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && (!out_valid || out_ch.ready)) begin
      out_delta  <= res_delta;
      out_status <= res_status;
    end
  end

  assign out_ch.valid  = out_valid;
  assign out_ch.delta  = out_delta;
  assign out_ch.status = out_status;

`ifndef SYNTHESIS
  a_sum_after_drain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SUM) |-> (!st1_valid && !st2_valid))
    else $error("tally pipeline busy during weighted sum");

  a_eval_start: assert property (@(posedge clk) disable iff (rst)
    (in_acc && is_eval && !bad_pos) |=> (state == ST_RD_P1))
    else $error("good evaluation did not start the walk");

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    walk_issue |-> (hi_r <= n_eff))
    else $error("walk runs beyond the item count");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_DONE))
    else $error("result shown outside the done state");

  a_sum_done: assert property (@(posedge clk) disable iff (rst)
    tr.done |-> (state == ST_SUM))
    else $error("sum finished outside the sum state");
`endif

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import smde_pkg::*;

  // spare command codes, accepted and ignored by the block
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_MID   = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int POOL_SIZE = 4;
  // ordering positions loaded up front; valid evaluations stay below this count
  localparam int LOAD_DEPTH = 32;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [FIELD_W-1:0] first_index;
    logic [FIELD_W-1:0] second_index;
    logic [VALUE_W-1:0] write_value;
  } cmd_item_t;

  typedef struct {
    logic signed [DELTA_W-1:0] delta;
    logic                      status;
  } delta_result_t;

  logic clk;
  logic rst;

  smde_in_if  in_ch();
  smde_out_if out_ch();
  smde_cfg_if cfg_ch();

  seriation_move_delta_engine_core dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  // predictor state
  logic [CODE_W-1:0]          code_mem [MAX_ITEMS][MAX_ITEMS];
  logic [ITEM_W-1:0]          order_mem [MAX_ITEMS];
  logic signed [WEIGHT_W-1:0] level_wt [LEVEL_COUNT];
  logic signed [TALLY_W-1:0]  level_cnt [LEVEL_COUNT];
  int                         items_in_use;

  cmd_item_t     pending_q[$];
  delta_result_t delta_q[$];
  int            fails;
  int            cycle_cnt;
  bit            no_gaps;

  // items whose pairwise matrix entries are all written
  logic [ITEM_W-1:0] item_pool [POOL_SIZE] = '{8'd3, 8'd64, 8'd170, 8'd255};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // tally helpers
  function automatic int item_at(int pos);
    return int'(order_mem[pos]);
  endfunction

  function automatic void tally_bump(int a, int b, int amt);
    logic [CODE_W-1:0] c;
    logic [31:0] amt_bits;
    c = code_mem[a][b];
    amt_bits = amt;
    if (int'(c) < LEVEL_COUNT)
      level_cnt[c] = level_cnt[c] + amt_bits[TALLY_W-1:0];
  endfunction

  function automatic void walk_swap(int s1, int s2, int n);
    int p1;
    int p2;
    int pi;
    int d1;
    int d2;
    p1 = item_at(s1);
    p2 = item_at(s2);
    for (int i = 0; i < n; i++) begin
      if (i == s1 || i == s2) continue;
      pi = item_at(i);
      d1 = i > s1 ? i - s1 : s1 - i;
      d2 = i > s2 ? i - s2 : s2 - i;
      tally_bump(p2, pi, d1 - d2);
      tally_bump(p1, pi, d2 - d1);
    end
  endfunction

  function automatic void walk_move(int s1, int s2, int n);
    int p1;
    int pa;
    int span;
    int step;
    p1 = item_at(s1);
    span = s1 > s2 ? s1 - s2 : s2 - s1;
    step = span + 1;
    if (s2 > s1) begin
      for (int a = s1 + 1; a <= s2; a++) begin
        pa = item_at(a);
        for (int b = s2 + 1; b < n; b++) tally_bump(item_at(b), pa, 1);
        for (int b = 0; b < s1; b++) tally_bump(item_at(b), pa, -1);
      end
      for (int a = 0; a < s1; a++) tally_bump(p1, item_at(a), span);
      for (int a = s2 + 1; a < n; a++) tally_bump(p1, item_at(a), -span);
      for (int a = s1 + 1; a <= s2; a++) begin
        step -= 2;
        tally_bump(p1, item_at(a), step);
      end
    end else begin
      for (int a = s2; a < s1; a++) begin
        pa = item_at(a);
        for (int b = s1 + 1; b < n; b++) tally_bump(item_at(b), pa, -1);
        for (int b = 0; b < s2; b++) tally_bump(item_at(b), pa, 1);
      end
      for (int a = 0; a < s2; a++) tally_bump(p1, item_at(a), -span);
      for (int a = s1 + 1; a < n; a++) tally_bump(p1, item_at(a), span);
      for (int a = s2; a < s1; a++) begin
        step -= 2;
        tally_bump(p1, item_at(a), -step);
      end
    end
  endfunction

  function automatic logic signed [DELTA_W-1:0] weighted_delta();
    longint acc;
    longint lim;
    acc = 0;
    lim = 64'sh0FFF_FFFF_FFFF_FFFF;
    for (int k = 0; k < LEVEL_COUNT; k++)
      acc += longint'(level_cnt[k]) * longint'(level_wt[k]);
    if (acc > lim) acc = lim;
    if (acc < -lim - 1) acc = -lim - 1;
    return acc[DELTA_W-1:0];
  endfunction

  // apply one accepted item to the predictor
  function automatic void predict_item(cmd_item_t it);
    int f;
    int s;
    delta_result_t r;
    f = int'(it.first_index);
    s = int'(it.second_index);
    case (it.cmd)
      CMD_WR_CODE: code_mem[f][s] = it.write_value[CODE_W-1:0];
      CMD_WR_ORDER: order_mem[f] = it.write_value[ITEM_W-1:0];
      CMD_WR_WEIGHT: if (f < LEVEL_COUNT) level_wt[f] = it.write_value;
      CMD_EVAL_SWAP, CMD_EVAL_MOVE: begin
        if (f == s || f >= items_in_use || s >= items_in_use) begin
          r.delta = '0;
          r.status = 1'b1;
        end else begin
          for (int k = 0; k < LEVEL_COUNT; k++) level_cnt[k] = '0;
          if (it.cmd == CMD_EVAL_SWAP) walk_swap(f, s, items_in_use);
          else walk_move(f, s, items_in_use);
          r.delta = weighted_delta();
          r.status = 1'b0;
        end
        delta_q.insert(delta_q.size(), r);
      end
      default: ;
    endcase
  endfunction

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid)
        predict_item('{in_ch.cmd, in_ch.first_index, in_ch.second_index, in_ch.write_value});
      if (pending_q.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 10)) begin
        cmd_item_t it;
        it = pending_q.pop_front();
        in_ch.valid        <= 1'b1;
        in_ch.cmd          <= it.cmd;
        in_ch.first_index  <= it.first_index;
        in_ch.second_index <= it.second_index;
        in_ch.write_value  <= it.write_value;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (delta_q.size() == 0) begin
          $error("unexpected result delta=%0d status=%0d", out_ch.delta, out_ch.status);
          fails++;
        end else begin
          delta_result_t e;
          e = delta_q.pop_front();
          if (out_ch.delta !== e.delta) begin
            $error("delta mismatch: expected %0d, actual %0d", e.delta, out_ch.delta);
            fails++;
          end
          if (out_ch.status !== e.status) begin
            $error("status mismatch: expected %0d, actual %0d", e.status, out_ch.status);
            fails++;
          end
        end
      end
      out_ch.ready <= no_gaps || ($urandom_range(0, 99) >= 10);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic void queue_item(logic [CMD_W-1:0] c, int f, int s, logic [31:0] v);
    cmd_item_t it;
    it.cmd = c;
    it.first_index = f[FIELD_W-1:0];
    it.second_index = s[FIELD_W-1:0];
    it.write_value = v;
    pending_q.insert(pending_q.size(), it);
  endfunction

  function automatic logic [31:0] pool_item();
    logic [31:0] v;
    v = $urandom;
    v[ITEM_W-1:0] = item_pool[$urandom_range(0, POOL_SIZE - 1)];
    return v;
  endfunction

  // random evaluation, span kept short on large orderings
  function automatic void queue_eval(int n);
    int eff;
    int s1;
    int s2;
    int sel;
    logic [CMD_W-1:0] c;
    eff = n > MAX_ITEMS ? MAX_ITEMS : n;
    c = $urandom_range(0, 1) ? CMD_EVAL_SWAP : CMD_EVAL_MOVE;
    sel = $urandom_range(0, 99);
    if (eff < 2 || sel < 5) begin
      s1 = $urandom_range(0, 255);
      s2 = s1;
    end else if (sel < 12 && eff < MAX_ITEMS) begin
      s1 = $urandom_range(0, eff - 1);
      s2 = $urandom_range(eff, 255);
      if ($urandom_range(0, 1)) begin
        sel = s1; s1 = s2; s2 = sel;
      end
    end else begin
      s1 = $urandom_range(0, eff - 1);
      if (eff > 40)
        s2 = (s1 + $urandom_range(1, 16)) % eff;
      else
        s2 = (s1 + $urandom_range(1, eff - 1)) % eff;
    end
    queue_item(c, s1, s2, $urandom);
  endfunction

  function automatic void queue_random(int n, int count);
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45)
        queue_eval(n);
      else if (sel < 60)
        queue_item(CMD_WR_CODE, item_pool[$urandom_range(0, POOL_SIZE - 1)],
                   item_pool[$urandom_range(0, POOL_SIZE - 1)], $urandom);
      else if (sel < 78)
        queue_item(CMD_WR_ORDER, $urandom_range(0, 255), $urandom_range(0, 255), pool_item());
      else if (sel < 92)
        queue_item(CMD_WR_WEIGHT, $urandom_range(0, 31), $urandom_range(0, 255), $urandom);
      else
        queue_item(CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)),
                   $urandom_range(0, 255), $urandom_range(0, 255), $urandom);
    end
  endfunction

  // hold until the block has drained everything
  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (pending_q.size() != 0 || in_ch.valid || delta_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_item_count(int v);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.item_count <= v[CNT_W-1:0];
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    items_in_use = v > MAX_ITEMS ? MAX_ITEMS : v;
  endtask

  task automatic run_phase(int count, int n);
    set_item_count(n);
    queue_random(n, count);
    wait_idle();
  endtask

  // stimulus
  initial begin
    fails = 0;
    cycle_cnt = 0;
    no_gaps = 1'b0;
    items_in_use = MAX_ITEMS;
    for (int k = 0; k < LEVEL_COUNT; k++) level_cnt[k] = '0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_WR_CODE;
    in_ch.first_index = '0;
    in_ch.second_index = '0;
    in_ch.write_value = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.item_count = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // load the leading positions, all pool pairs and all level weights
    for (int p = 0; p < LOAD_DEPTH; p++) queue_item(CMD_WR_ORDER, p, 0, pool_item());
    for (int a = 0; a < POOL_SIZE; a++)
      for (int b = 0; b < POOL_SIZE; b++)
        queue_item(CMD_WR_CODE, item_pool[a], item_pool[b], $urandom);
    for (int k = 0; k < LEVEL_COUNT; k++) queue_item(CMD_WR_WEIGHT, k, 0, $urandom);

    // directed: weight extremes, an ignored weight write, edge writes, equal positions at full item count
    queue_item(CMD_WR_WEIGHT, 0, 0, 32'h8000_0000);
    queue_item(CMD_WR_WEIGHT, 15, 255, 32'h7FFF_FFFF);
    queue_item(CMD_WR_WEIGHT, 255, 0, 32'h1234_5678);
    queue_item(CMD_WR_ORDER, 255, 255, 32'hFFFF_FF00);
    queue_item(CMD_WR_CODE, 255, 255, 32'hFFFF_FFFF);
    queue_item(CMD_WR_CODE, 0, 0, 32'h0000_0000);
    queue_item(CMD_EVAL_SWAP, 7, 7, 32'h0);
    queue_item(CMD_EVAL_MOVE, 255, 255, 32'h0);
    queue_item(CMD_SPARE_FIRST, 1, 2, 32'hFFFF_FFFF);
    queue_item(CMD_SPARE_LAST, 3, 4, 32'h0);
    queue_item(CMD_SPARE_MID, 5, 6, 32'h0);
    wait_idle();

    // item count above the store size
    set_item_count(511);
    queue_item(CMD_EVAL_SWAP, 9, 9, 32'h0);
    wait_idle();

    // directed: full-span swaps and moves, adjacent moves, bad positions
    set_item_count(LOAD_DEPTH);
    queue_item(CMD_EVAL_SWAP, 0, LOAD_DEPTH - 1, 32'h0);
    queue_item(CMD_EVAL_SWAP, LOAD_DEPTH - 1, 0, 32'hFFFF_FFFF);
    queue_item(CMD_EVAL_MOVE, 0, LOAD_DEPTH - 1, 32'h0);
    queue_item(CMD_EVAL_MOVE, LOAD_DEPTH - 1, 0, 32'h0);
    queue_item(CMD_EVAL_MOVE, 10, 11, 32'h0);
    queue_item(CMD_EVAL_MOVE, 11, 10, 32'h0);
    queue_item(CMD_EVAL_MOVE, LOAD_DEPTH - 1, LOAD_DEPTH, 32'h0);
    queue_item(CMD_EVAL_SWAP, 200, 3, 32'h0);
    wait_idle();

    // small orderings, including those too short to evaluate, then random phases up to the loaded depth
    set_item_count(1);
    queue_item(CMD_EVAL_SWAP, 0, 1, 32'h0);
    queue_item(CMD_EVAL_MOVE, 1, 0, 32'h0);
    wait_idle();
    set_item_count(0);
    queue_item(CMD_EVAL_SWAP, 0, 1, 32'h0);
    wait_idle();
    run_phase(12, 2);
    run_phase(12, 7);
    no_gaps = 1'b1;
    run_phase(14, 20);
    no_gaps = 1'b0;
    run_phase(12, LOAD_DEPTH);

    wait_idle();
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
